// ----- rtl/core/rme_pkg.sv -----
package rme_pkg;

    // operand and result width
    localparam int WIDTH = 16;
    localparam int CNT_W = $clog2(WIDTH);

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    localparam logic [WIDTH-1:0] EXPONENT_RESET = WIDTH'(103);
    localparam logic [WIDTH-1:0] MODULUS_RESET  = WIDTH'(143);
    localparam logic [WIDTH-1:0] ONE            = WIDTH'(1);
    localparam logic [WIDTH-1:0] TWO            = WIDTH'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } state_t;

    // request to the shared modular multiplier
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] op_a;
        logic [WIDTH-1:0] op_b;
        logic [WIDTH-1:0] modulus;
    } mm_req_t;

    // status from the shared modular multiplier
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIDTH-1:0] product;
    } mm_stat_t;

endpackage

// ----- rtl/core/rme_mulmod.sv -----
// bit-serial interleaved modular multiply: product = (op_a * op_b) mod modulus
// op_a must be below modulus, one bit of op_b per cycle, msb first
module rme_mulmod
    import rme_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mm_req_t  req,
    output mm_stat_t stat
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] n_reg, n_next;

    logic [WIDTH:0] dbl;
    logic [WIDTH:0] dbl_red;
    logic [WIDTH:0] sum;
    logic [WIDTH:0] sum_red;
    logic [WIDTH:0] n_ext;

    always_comb begin
        n_ext   = {1'b0, n_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= n_ext) ? (dbl - n_ext) : dbl;
        sum     = dbl_red + (b_reg[WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= n_ext) ? (sum - n_ext) : sum;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        n_next    = n_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            r_next    = '0;
            a_next    = req.op_a;
            b_next    = req.op_b;
            n_next    = req.modulus;
        end else if (busy_reg) begin
            r_next   = sum_red[WIDTH-1:0];
            b_next   = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        r_reg <= r_next;
        a_reg <= a_next;
        b_reg <= b_next;
        n_reg <= n_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.product = r_reg;

endmodule

// ----- rtl/core/rsa_modular_exponentiation.sv -----
// sequence: one reduce of c, then for each exponent bit up to its top one a multiply
//   (bit set only) and a square; a modulus below two answers 0 without any multiply
// throughput: one word at a time; every modular multiply runs on the
//   single bit-serial multiplier, and that unit sets the rate
// reset: synchronous active-low aresetn; exponent 103, modulus 143, channels empty
module rsa_modular_exponentiation
    import rme_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel, tdata: ciphertext [15:0]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WIDTH-1:0]      s_tdata,
    // result channel, tdata: plaintext [15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [WIDTH-1:0]      m_tdata,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // configuration registers
    logic [WIDTH-1:0] exponent_reg, exponent_next;
    logic [WIDTH-1:0] modulus_reg, modulus_next;
    logic             cfg_write;

    // sequencer state and working values
    state_t           state_reg, state_next;
    logic [WIDTH-1:0] acc_reg, acc_next;     // running result
    logic [WIDTH-1:0] base_reg, base_next;   // c^(2^k) mod n
    logic [WIDTH-1:0] d_reg, d_next;         // exponent bits still to go
    logic [WIDTH-1:0] n_reg, n_next;         // modulus snapshot for this word
    logic [WIDTH-1:0] m_tdata_reg, m_tdata_next;
    logic             m_valid_reg, m_valid_next;

    // sequencer outputs
    logic             accept;
    logic             out_load;
    logic             small_mod;
    mm_req_t          mm_req;
    mm_stat_t         mm_stat;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (cfg_write) begin
            case (paddr[2])
                REG_EXPONENT: exponent_next = pwdata[WIDTH-1:0];
                REG_MODULUS:  modulus_next  = pwdata[WIDTH-1:0];
                default:      exponent_next = exponent_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_EXPONENT: prdata = APB_DATA_W'(exponent_reg);
            REG_MODULUS:  prdata = APB_DATA_W'(modulus_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- shared modular multiplier ----------------
    rme_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .stat    (mm_stat)
    );

    // ---------------- sequencer: next state ----------------
    assign small_mod = (modulus_reg < TWO);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                // modulus below two answers 0 without any multiply
                if (s_tvalid)
                    state_next = small_mod ? ST_DONE : ST_REDUCE;
            end
            ST_REDUCE: begin
                if (mm_stat.done)
                    state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (d_reg == '0)
                    state_next = ST_DONE;
                else if (d_reg[0])
                    state_next = ST_MUL;
                else
                    state_next = ST_SQR;
            end
            ST_MUL: begin
                if (mm_stat.done)
                    state_next = ST_SQR;
            end
            ST_SQR: begin
                if (mm_stat.done)
                    state_next = ST_CHECK;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        accept         = 1'b0;
        out_load       = 1'b0;
        mm_req.start   = 1'b0;
        mm_req.op_a    = acc_reg;
        mm_req.op_b    = base_reg;
        mm_req.modulus = n_reg;
        case (state_reg)
            ST_IDLE: begin
                accept = s_tvalid;
                // first pass reduces c: (1 * c) mod n
                mm_req.start   = s_tvalid & ~small_mod;
                mm_req.op_a    = ONE;
                mm_req.op_b    = s_tdata;
                mm_req.modulus = modulus_reg;
            end
            ST_CHECK: begin
                if (d_reg != '0) begin
                    mm_req.start = 1'b1;
                    if (!d_reg[0])
                        mm_req.op_a = base_reg;
                end
            end
            ST_MUL: begin
                // chain straight into the square
                mm_req.start = mm_stat.done;
                mm_req.op_a  = base_reg;
            end
            ST_DONE: begin
                out_load = ~m_valid_reg | m_tready;
            end
            default: accept = 1'b0;
        endcase
    end

    // ---------------- working values ----------------
    always_comb begin
        acc_next     = acc_reg;
        base_next    = base_reg;
        d_next       = d_reg;
        n_next       = n_reg;
        m_tdata_next = m_tdata_reg;
        m_valid_next = m_valid_reg;

        if (accept) begin
            acc_next = small_mod ? '0 : ONE;
            d_next   = exponent_reg;
            n_next   = modulus_reg;
        end

        if (mm_stat.done) begin
            case (state_reg)
                ST_REDUCE: base_next = mm_stat.product;
                ST_MUL:    acc_next  = mm_stat.product;
                ST_SQR: begin
                    base_next = mm_stat.product;
                    d_next    = d_reg >> 1;
                end
                default:   base_next = base_reg;
            endcase
        end

        if (m_tready)
            m_valid_next = 1'b0;
        if (out_load) begin
            m_tdata_next = acc_reg;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
        end
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        d_reg       <= d_next;
        n_reg       <= n_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- assertions ----------------

    // the multiplier is never left running while a new word can come in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mm_stat.busy)
        else $error("multiplier busy while idle");

    // a finished multiply only lands in a state that waits for one
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_stat.done |-> (state_reg == ST_REDUCE || state_reg == ST_MUL ||
                          state_reg == ST_SQR))
        else $error("multiply result with no consumer");

    // operands stay reduced between multiplies
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (acc_reg < n_reg && base_reg < n_reg))
        else $error("operand not reduced");

    // every new result is below the modulus, or 0 for a modulus below two
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_tdata_reg < n_reg || m_tdata_reg == '0))
        else $error("result out of range");

endmodule
